// ===== rtl/integer_set_table_macros.svh =====
// Assertion macros for the integer set table.
// Used by the top level only; expects clk and arst_n in scope where expanded.
`ifndef INTEGER_SET_TABLE_MACROS_SVH
`define INTEGER_SET_TABLE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ITBL_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition in one cycle that implies another in the same cycle.
`define ITBL_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition in one cycle that implies another in the next cycle.
`define ITBL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/itbl_pkg.sv =====
// Shared types and constants of the integer set table.
// No dependencies; used by integer_set_table.
package itbl_pkg;

	// Operation codes of a request.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// Status codes of a response.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_PRESENT  = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_RANGE    = 3'd4;

	// Register file.
	localparam int unsigned APB_ADDR_W   = 3;
	localparam int unsigned APB_DATA_W   = 32;
	localparam int unsigned CAP_W        = 7;
	localparam logic [CAP_W-1:0] CAPACITY_RESET = 7'd64;
	localparam logic REG_CAPACITY = 1'b0;   // word index, taken from paddr[2]

	typedef struct packed {
		logic [1:0]         opcode;
		logic signed [31:0] value;
		logic [5:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               found;
		logic signed [31:0] item_value;
		logic [6:0]         member_count;
	} rsp_t;

endpackage

// ===== rtl/integer_set_table.sv =====
// Integer set table: top level, holding the member memory and its sequencer.
// Depends on itbl_pkg and integer_set_table_macros.svh.
//
// The set is kept as a compact array in a single-port-write, registered-read
// memory, and one 32-bit comparator walks it under a small sequencer, so a
// request is taken only while the block is idle. A search reads and compares
// one entry at a time; a successful remove then moves each later entry down
// by one, and a read by index reads the memory only when the index is in range.
// The response waits in an output register; the next request is taken once it
// has been loaded there. Capacity is written through the APB port at address 0.
`include "integer_set_table_macros.svh"

module integer_set_table #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [itbl_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [itbl_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [itbl_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	input  logic                                 req_valid,
	output logic                                 req_ready,
	input  itbl_pkg::req_t                       req,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output itbl_pkg::rsp_t                       rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_SRCH_RD  = 4'd1;
	localparam logic [3:0] S_SRCH_CMP = 4'd2;
	localparam logic [3:0] S_SHIFT_RD = 4'd3;
	localparam logic [3:0] S_SHIFT_LD = 4'd4;
	localparam logic [3:0] S_SHIFT_WR = 4'd5;
	localparam logic [3:0] S_RD_LD    = 4'd6;
	localparam logic [3:0] S_RD_OUT   = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0]                     state_q;
	logic [CW-1:0]                  count_q;
	logic [CW-1:0]                  idx_q;
	logic [itbl_pkg::CAP_W-1:0]     capacity_q;
	logic [1:0]                     op_q;
	logic signed [31:0]             value_q;
	logic [2:0]                     status_q;
	logic                           found_q;
	logic signed [31:0]             item_q;
	logic                           rsp_valid_q;
	itbl_pkg::rsp_t                 rsp_q;

	logic signed [31:0]             mem [DEPTH];
	logic signed [31:0]             rd_data_q;

	logic                           req_fire;
	logic                           cfg_write;
	logic                           at_end;
	logic                           match;
	logic                           table_full;
	logic [31:0]                    limit;
	logic                           append;
	logic                           mem_we;
	logic [AW-1:0]                  wr_addr;
	logic signed [31:0]             wr_data;
	logic                           out_free;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == itbl_pkg::REG_CAPACITY) ?
		itbl_pkg::APB_DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= itbl_pkg::CAPACITY_RESET;
		end else if (cfg_write && paddr[2] == itbl_pkg::REG_CAPACITY) begin
			capacity_q <= pwdata[itbl_pkg::CAP_W-1:0];
		end
	end

	// Effective limit is the smaller of the capacity and the memory depth.
	assign limit = (32'(capacity_q) > 32'(DEPTH)) ? 32'(DEPTH) : 32'(capacity_q);
	assign table_full = 32'(count_q) >= limit;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign at_end    = (idx_q == count_q);
	assign match     = (rd_data_q == value_q);
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign append  = (state_q == S_SRCH_RD) && at_end && (op_q == itbl_pkg::OP_ADD)
		&& !table_full;
	assign mem_we  = append || (state_q == S_SHIFT_WR);
	assign wr_addr = (state_q == S_SHIFT_WR) ? AW'(idx_q - CW'(1)) : AW'(count_q);
	assign wr_data = (state_q == S_SHIFT_WR) ? rd_data_q : value_q;

	// Member memory: one write port, registered read at the walking index.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[idx_q[AW-1:0]];
	end

	// A new response is loaded in the same cycle as the old one leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			op_q        <= itbl_pkg::OP_ADD;
			value_q     <= '0;
			status_q    <= itbl_pkg::ST_OK;
			found_q     <= 1'b0;
			item_q      <= '0;
			rsp_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						op_q     <= req.opcode;
						value_q  <= req.value;
						status_q <= itbl_pkg::ST_OK;
						found_q  <= 1'b0;
						item_q   <= '0;
						if (req.opcode == itbl_pkg::OP_READ) begin
							if (32'(req.position) < 32'(count_q)) begin
								idx_q   <= CW'(req.position);
								state_q <= S_RD_LD;
							end else begin
								status_q <= itbl_pkg::ST_RANGE;
								state_q  <= S_DONE;
							end
						end else begin
							idx_q   <= '0;
							state_q <= S_SRCH_RD;
						end
					end
				end
				S_SRCH_RD: begin
					// Reaching the count means the value is not a member.
					if (at_end) begin
						case (op_q)
							itbl_pkg::OP_ADD: begin
								if (table_full) begin
									status_q <= itbl_pkg::ST_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							itbl_pkg::OP_REMOVE: status_q <= itbl_pkg::ST_NOTFOUND;
							default: found_q <= 1'b0;
						endcase
						state_q <= S_DONE;
					end else begin
						state_q <= S_SRCH_CMP;
					end
				end
				S_SRCH_CMP: begin
					if (match) begin
						case (op_q)
							itbl_pkg::OP_ADD: begin
								status_q <= itbl_pkg::ST_PRESENT;
								state_q  <= S_DONE;
							end
							itbl_pkg::OP_REMOVE: state_q <= S_SHIFT_RD;
							default: begin
								found_q <= 1'b1;
								state_q <= S_DONE;
							end
						endcase
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_SHIFT_RD: begin
					// Move each later entry down by one, then drop the last.
					if ((idx_q + CW'(1)) >= count_q) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SHIFT_LD;
					end
				end
				S_SHIFT_LD: state_q <= S_SHIFT_WR;
				S_SHIFT_WR: state_q <= S_SHIFT_RD;
				S_RD_LD:    state_q <= S_RD_OUT;
				S_RD_OUT: begin
					item_q  <= rd_data_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						rsp_q.status       <= status_q;
						rsp_q.found        <= found_q;
						rsp_q.item_value   <= item_q;
						rsp_q.member_count <= 7'(count_q);
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ITBL_ASSERT_ALWAYS(a_count_bound, 32'(count_q) <= 32'(DEPTH), "member count above depth")
	`ITBL_ASSERT_NEXT(a_count_hold, req_fire, count_q == $past(count_q), "count moved on accept")
	`ITBL_ASSERT_SAME(a_rsp_from_done, $rose(rsp_valid_q), $past(state_q) == S_DONE,
		"response raised outside the completion state")
	`ITBL_ASSERT_SAME(a_write_in_range, mem_we, idx_q <= count_q && 32'(count_q) <= 32'(DEPTH),
		"memory written beyond the live entries")

endmodule
